// File: design/qpf_pkg.sv
// Shared widths, register codes, reject codes and types for the quad plausibility filter.
// No dependencies; every other design file imports this package.
package qpf_pkg;

  localparam int CW    = 16;              // coordinate width, signed
  localparam int FB    = 4;               // coordinate fraction bits
  localparam int DW    = CW + 1;          // corner difference, signed
  localparam int PW    = 2 * DW;          // product of two differences, signed
  localparam int SW    = PW + 1;          // sum of two products, signed
  localparam int MAGW  = 2 * CW + 1;      // magnitude of a sum of two products
  localparam int L2W   = 2 * CW + 1;      // squared edge length
  localparam int SQ_SH = 14;              // extra fraction bits of the radicand
  localparam int EW    = (L2W + SQ_SH + 1) / 2;  // edge length width
  localparam int RPW   = 2 * EW;          // radicand, padded to whole bit pairs
  localparam int RMW   = EW + 2;          // square root remainder
  localparam int DIMW  = 11;              // image dimension
  localparam int WHW   = 2 * DIMW;        // image area
  localparam int FRW   = 16;              // Q0.16 fraction
  localparam int CCW   = 17;              // corner cosine limit
  localparam int MBW   = 3;               // border corner limit
  localparam int BW    = CW + FB + 8;     // border compare, signed

  localparam int IN_BITS = 8 * CW + 2 * DIMW;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W   = 8;
  localparam int CODE_W  = 4;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 17;

  // area: a2 * 2^15 against frac * W * H * 2^(2*FB)
  localparam int AMW   = FRW + WHW;
  localparam int ASH_L = (2 * FB > 15) ? 0 : 15 - 2 * FB;
  localparam int ASH_R = (2 * FB > 15) ? 2 * FB - 15 : 0;
  localparam int ACW   = (MAGW + ASH_L > AMW + ASH_R) ? MAGW + ASH_L : AMW + ASH_R;

  // edge: emin * 2^16 against frac * min(W,H) * 2^(FB+7)
  localparam int ESH = 9 - FB;
  localparam int EMW = FRW + DIMW;
  localparam int ECW = (EW + ESH > EMW) ? EW + ESH : EMW;

  // ratios: lo * 2^16 against frac * hi
  localparam int RLW      = EW + 1;
  localparam int RATIO_SH = 16;
  localparam int RCW      = RLW + RATIO_SH + 1;

  // cosines: |dot| * 2^30 against frac * Ea * Eb
  localparam int COS_SH = 30;
  localparam int PPW    = CCW + EW;
  localparam int CMPW   = (MAGW + COS_SH > CCW + 2 * EW) ? MAGW + COS_SH : CCW + 2 * EW;
  localparam logic [CCW-1:0] COS_ONE = CCW'(65536);

  localparam logic [CFG_IW-1:0] CFG_MIN_AREA_FRAC      = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_MAX_AREA_FRAC      = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MIN_EDGE_FRAC      = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_MIN_ASPECT         = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_MIN_SIDE_RATIO     = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_MIN_PARALLEL_COS   = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_MAX_CORNER_COS     = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_MAX_BORDER_CORNERS = 3'd7;

  localparam logic [CODE_W-1:0] REJ_NONE     = 4'd0;
  localparam logic [CODE_W-1:0] REJ_SMALL    = 4'd1;
  localparam logic [CODE_W-1:0] REJ_LARGE    = 4'd2;
  localparam logic [CODE_W-1:0] REJ_EDGE     = 4'd3;
  localparam logic [CODE_W-1:0] REJ_ASPECT   = 4'd4;
  localparam logic [CODE_W-1:0] REJ_RATIO    = 4'd5;
  localparam logic [CODE_W-1:0] REJ_PARALLEL = 4'd6;
  localparam logic [CODE_W-1:0] REJ_CORNER   = 4'd7;
  localparam logic [CODE_W-1:0] REJ_BORDER   = 4'd8;

  typedef struct packed {
    logic [FRW-1:0] min_area_frac;
    logic [FRW-1:0] max_area_frac;
    logic [FRW-1:0] min_edge_frac;
    logic [FRW-1:0] min_aspect;
    logic [FRW-1:0] min_side_ratio;
    logic [FRW-1:0] min_parallel_cos;
    logic [CCW-1:0] max_corner_cos;
    logic [MBW-1:0] max_border_corners;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_area_frac:      16'd2621,
    max_area_frac:      16'd65208,
    min_edge_frac:      16'd1966,
    min_aspect:         16'd10486,
    min_side_ratio:     16'd6554,
    min_parallel_cos:   16'd16384,
    max_corner_cos:     17'd65405,
    max_border_corners: 3'd4
  };

  // dot[0..1]: opposite edge pairs, dot[2..5]: corners 0..3
  typedef struct packed {
    logic [5:0][MAGW-1:0] dot;
    logic [DIMW-1:0]      m;
    logic                 area_low;
    logic                 area_high;
    logic                 border;
  } sb_t;

  typedef struct packed {
    logic [3:0][L2W-1:0] l2;
    sb_t                 sb;
  } sqin_t;

  function automatic logic [MAGW-1:0] mag(input logic signed [SW-1:0] v);
    return MAGW'((v < 0) ? -v : v);
  endfunction

endpackage

// File: design/quad_plausibility_filter_core.sv
// Quad plausibility filter top level: configuration registers and the full pipeline.
// Depends on qpf_pkg, qpf_front, qpf_sqrt, qpf_judge and qpf_outbuf.
//
// Takes one quad (four corners in Q12.4 plus the image size) per clock while s_tready_o is
// high and returns one word per quad, in order: a pass flag and the first failing check. A quad
// passes 32 register stages between s_tdata_i and m_tdata_o: four front stages for differences,
// products and sums, a 24-stage square root that settles one bit of each edge length per stage,
// three compare stages and the output register. A skid word behind the output register takes
// the next result after m_tready_i drops; once a word waits there, s_tready_o falls and every
// stage holds until the output register frees. Configuration writes are always taken and must
// only be issued while no quad is in flight.
module quad_plausibility_filter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  // tl_x, tl_y, tr_x, tr_y, br_x, br_y, bl_x, bl_y, image_width, image_height, zero pad
  input  logic [qpf_pkg::IN_W-1:0]    s_tdata_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  // plausible, reject_code, zero pad
  output logic [qpf_pkg::OUT_W-1:0]   m_tdata_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [qpf_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [qpf_pkg::CFG_DW-1:0]  cfg_data_i
);
  import qpf_pkg::*;

  cfg_t              cfg_q;
  logic              en;
  logic              fr_valid, sq_valid, jd_valid;
  sqin_t             fr_data;
  logic [3:0][EW-1:0] sq_len;
  sb_t               sq_sb;
  logic [CODE_W-1:0] jd_code;

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MIN_AREA_FRAC:      cfg_q.min_area_frac      <= FRW'(cfg_data_i);
        CFG_MAX_AREA_FRAC:      cfg_q.max_area_frac      <= FRW'(cfg_data_i);
        CFG_MIN_EDGE_FRAC:      cfg_q.min_edge_frac      <= FRW'(cfg_data_i);
        CFG_MIN_ASPECT:         cfg_q.min_aspect         <= FRW'(cfg_data_i);
        CFG_MIN_SIDE_RATIO:     cfg_q.min_side_ratio     <= FRW'(cfg_data_i);
        CFG_MIN_PARALLEL_COS:   cfg_q.min_parallel_cos   <= FRW'(cfg_data_i);
        CFG_MAX_CORNER_COS:     cfg_q.max_corner_cos     <= CCW'(cfg_data_i);
        CFG_MAX_BORDER_CORNERS: cfg_q.max_border_corners <= MBW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  qpf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_tvalid_i),
    .data_i  (s_tdata_i),
    .cfg_i   (cfg_q),
    .valid_o (fr_valid),
    .data_o  (fr_data)
  );

  qpf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .data_i  (fr_data),
    .valid_o (sq_valid),
    .len_o   (sq_len),
    .sb_o    (sq_sb)
  );

  qpf_judge u_judge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .len_i   (sq_len),
    .sb_i    (sq_sb),
    .cfg_i   (cfg_q),
    .valid_o (jd_valid),
    .code_o  (jd_code)
  );

  qpf_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (jd_valid),
    .code_i     (jd_code),
    .ready_o    (en),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule

// File: design/qpf_front.sv
// Front stages: input capture, edge vectors, products, squared lengths, area and border checks.
// Depends on qpf_pkg.
module qpf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [qpf_pkg::IN_W-1:0] data_i,
  input  qpf_pkg::cfg_t    cfg_i,
  output logic             valid_o,
  output qpf_pkg::sqin_t   data_o
);
  import qpf_pkg::*;

  localparam logic signed [BW-1:0] HUNDRED = BW'(100);
  localparam logic signed [BW-1:0] ONE     = BW'(1);
  localparam logic [DIMW-1:0]      T_MIN   = DIMW'(400);

  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [CW-1:0] x1_q [4];
  logic signed [CW-1:0] y1_q [4];
  logic [DIMW-1:0]      w1_q, h1_q;

  logic signed [DW-1:0] ex_d [4];
  logic signed [DW-1:0] ey_d [4];
  logic signed [DW-1:0] ex2_q [4];
  logic signed [DW-1:0] ey2_q [4];
  logic signed [DW-1:0] dx02_q, dy13_q, dx13_q, dy02_q;
  logic [WHW-1:0]       wh2_q;
  logic [DIMW-1:0]      m_d, m2_q, m3_q;
  logic [3:0]           near_d, near2_q;

  logic [DIMW-1:0]      tmax;
  logic signed [BW-1:0] t, xr, yr, px, py;

  logic signed [PW-1:0] sqx3_q [4];
  logic signed [PW-1:0] sqy3_q [4];
  logic signed [PW-1:0] pa3_q, pb3_q;
  logic signed [PW-1:0] dpx3_q [6];
  logic signed [PW-1:0] dpy3_q [6];
  logic [AMW-1:0]       mina3_q, maxa3_q;
  logic [MBW-1:0]       cnt;
  logic                 bord3_q;

  logic [MAGW-1:0]      a2;
  logic [ACW-1:0]       a_lhs;
  sqin_t                d4_d, d4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        x1_q[i] <= data_i[2*i*CW +: CW];
        y1_q[i] <= data_i[(2*i+1)*CW +: CW];
      end
      w1_q <= data_i[8*CW +: DIMW];
      h1_q <= data_i[8*CW+DIMW +: DIMW];
    end
  end

  always_comb begin
    ex_d[0] = DW'(x1_q[1]) - DW'(x1_q[0]);
    ey_d[0] = DW'(y1_q[1]) - DW'(y1_q[0]);
    ex_d[1] = DW'(x1_q[2]) - DW'(x1_q[1]);
    ey_d[1] = DW'(y1_q[2]) - DW'(y1_q[1]);
    ex_d[2] = DW'(x1_q[2]) - DW'(x1_q[3]);
    ey_d[2] = DW'(y1_q[2]) - DW'(y1_q[3]);
    ex_d[3] = DW'(x1_q[3]) - DW'(x1_q[0]);
    ey_d[3] = DW'(y1_q[3]) - DW'(y1_q[0]);
    m_d  = (w1_q < h1_q) ? w1_q : h1_q;
    tmax = (m_d > T_MIN) ? m_d : T_MIN;
    t    = $signed(BW'(tmax) << FB);
    xr   = ((($signed(BW'(w1_q)) - ONE) * HUNDRED) <<< FB) - t;
    yr   = ((($signed(BW'(h1_q)) - ONE) * HUNDRED) <<< FB) - t;
    for (int i = 0; i < 4; i++) begin
      px = BW'(x1_q[i]) * HUNDRED;
      py = BW'(y1_q[i]) * HUNDRED;
      near_d[i] = (px <= t) || (py <= t) || (px >= xr) || (py >= yr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex2_q   <= ex_d;
      ey2_q   <= ey_d;
      dx02_q  <= DW'(x1_q[0]) - DW'(x1_q[2]);
      dy13_q  <= DW'(y1_q[1]) - DW'(y1_q[3]);
      dx13_q  <= DW'(x1_q[1]) - DW'(x1_q[3]);
      dy02_q  <= DW'(y1_q[0]) - DW'(y1_q[2]);
      wh2_q   <= WHW'(w1_q) * WHW'(h1_q);
      m2_q    <= m_d;
      near2_q <= near_d;
    end
  end

  assign cnt = MBW'(near2_q[0]) + MBW'(near2_q[1]) + MBW'(near2_q[2]) + MBW'(near2_q[3]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        sqx3_q[i] <= ex2_q[i] * ex2_q[i];
        sqy3_q[i] <= ey2_q[i] * ey2_q[i];
      end
      for (int j = 0; j < 2; j++) begin
        dpx3_q[j] <= ex2_q[j] * ex2_q[j+2];
        dpy3_q[j] <= ey2_q[j] * ey2_q[j+2];
      end
      for (int k = 0; k < 4; k++) begin
        dpx3_q[k+2] <= ex2_q[(k+3)&3] * ex2_q[k];
        dpy3_q[k+2] <= ey2_q[(k+3)&3] * ey2_q[k];
      end
      pa3_q   <= dx02_q * dy13_q;
      pb3_q   <= dx13_q * dy02_q;
      mina3_q <= AMW'(cfg_i.min_area_frac) * AMW'(wh2_q);
      maxa3_q <= AMW'(cfg_i.max_area_frac) * AMW'(wh2_q);
      m3_q    <= m2_q;
      bord3_q <= cnt > cfg_i.max_border_corners;
    end
  end

  always_comb begin
    a2    = mag(SW'(pa3_q) - SW'(pb3_q));
    a_lhs = ACW'(a2) << ASH_L;
    for (int i = 0; i < 4; i++) begin
      d4_d.l2[i] = L2W'(sqx3_q[i]) + L2W'(sqy3_q[i]);
    end
    for (int j = 0; j < 6; j++) begin
      d4_d.sb.dot[j] = mag(SW'(dpx3_q[j]) + SW'(dpy3_q[j]));
    end
    d4_d.sb.m         = m3_q;
    d4_d.sb.area_low  = a_lhs < (ACW'(mina3_q) << ASH_R);
    d4_d.sb.area_high = a_lhs > (ACW'(maxa3_q) << ASH_R);
    d4_d.sb.border    = bord3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d4_q <= d4_d;
    end
  end

  assign valid_o = v4_q;
  assign data_o  = d4_q;

endmodule

// File: design/qpf_sqrt.sv
// Pipelined integer square root of four squared edge lengths, one root bit per stage.
// Carries the check sideband alongside; depends on qpf_pkg.
module qpf_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  qpf_pkg::sqin_t            data_i,
  output logic                      valid_o,
  output logic [3:0][qpf_pkg::EW-1:0] len_o,
  output qpf_pkg::sb_t              sb_o
);
  import qpf_pkg::*;

  logic           v_q   [EW];
  sb_t            sb_q  [EW];
  logic [RMW-1:0] rem_q [EW][4];
  logic [EW-1:0]  root_q[EW][4];
  logic [RPW-1:0] rad_q [EW][4];

  logic [RMW-1:0] rem_d [EW][4];
  logic [EW-1:0]  root_d[EW][4];
  logic [RPW-1:0] rad_d [EW][4];

  always_comb begin
    logic [RMW-1:0] rin, cur, trial;
    logic [EW-1:0]  oin;
    logic [RPW-1:0] din;
    for (int s = 0; s < EW; s++) begin
      for (int l = 0; l < 4; l++) begin
        if (s == 0) begin
          rin = '0;
          oin = '0;
          din = RPW'(data_i.l2[l]) << SQ_SH;
        end else begin
          rin = rem_q[s-1][l];
          oin = root_q[s-1][l];
          din = rad_q[s-1][l];
        end
        cur   = {rin[RMW-3:0], din[RPW-1 -: 2]};
        trial = {oin, 2'b01};
        if (cur >= trial) begin
          rem_d[s][l]  = cur - trial;
          root_d[s][l] = {oin[EW-2:0], 1'b1};
        end else begin
          rem_d[s][l]  = cur;
          root_d[s][l] = {oin[EW-2:0], 1'b0};
        end
        rad_d[s][l] = din << 2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < EW; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < EW; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= data_i.sb;
      for (int s = 1; s < EW; s++) sb_q[s] <= sb_q[s-1];
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) len_o[l] = root_q[EW-1][l];
  end

  assign valid_o = v_q[EW-1];
  assign sb_o    = sb_q[EW-1];

endmodule

// File: design/qpf_judge.sv
// Length-based checks: edge, aspect, side ratio, parallelism and corner cosines, then the
// first failing check, area and border flags included, as reject code. Depends on qpf_pkg.
module qpf_judge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [3:0][qpf_pkg::EW-1:0] len_i,
  input  qpf_pkg::sb_t                sb_i,
  input  qpf_pkg::cfg_t               cfg_i,
  output logic                        valid_o,
  output logic [qpf_pkg::CODE_W-1:0]  code_o
);
  import qpf_pkg::*;

  logic v1_q, v2_q, v3_q;

  // stage 1
  logic [EW-1:0]    m01, m23;
  logic [RLW-1:0]   sa, sb;
  logic [EW-1:0]    emin1_q;
  logic [EMW-1:0]   em1_q;
  logic [RLW-1:0]   lo1_q [3];
  logic [RLW-1:0]   hi1_q [3];
  logic [RPW-1:0]   pe1_q [6];
  logic [3:0]       zero1_q;
  sb_t              sb1_q;

  // stage 2
  logic [FRW-1:0]   rfrac;
  logic             edge2_q, aspect2_q, ratio2_q;
  logic [PPW-1:0]   pph2_q [6];
  logic [PPW-1:0]   ppl2_q [6];
  logic [5:0]       zero2_q;
  logic [MAGW-1:0]  dot2_q [6];
  logic             small2_q, large2_q, border2_q;
  logic [2:0]       rfail;

  // stage 3
  logic [CMPW-1:0]  prod, lhs;
  logic [1:0]       par_fail;
  logic [3:0]       cor_fail;
  logic [CODE_W-1:0] code_d, code3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign m01 = (len_i[0] < len_i[1]) ? len_i[0] : len_i[1];
  assign m23 = (len_i[2] < len_i[3]) ? len_i[2] : len_i[3];
  assign sa  = RLW'(len_i[0]) + RLW'(len_i[2]);
  assign sb  = RLW'(len_i[1]) + RLW'(len_i[3]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      emin1_q  <= (m01 < m23) ? m01 : m23;
      em1_q    <= EMW'(cfg_i.min_edge_frac) * EMW'(sb_i.m);
      lo1_q[0] <= (sa < sb) ? sa : sb;
      hi1_q[0] <= (sa < sb) ? sb : sa;
      for (int j = 0; j < 2; j++) begin
        lo1_q[j+1] <= RLW'((len_i[j] < len_i[j+2]) ? len_i[j] : len_i[j+2]);
        hi1_q[j+1] <= RLW'((len_i[j] < len_i[j+2]) ? len_i[j+2] : len_i[j]);
        pe1_q[j]   <= RPW'(len_i[j]) * RPW'(len_i[j+2]);
      end
      for (int k = 0; k < 4; k++) begin
        pe1_q[k+2] <= RPW'(len_i[(k+3)&3]) * RPW'(len_i[k]);
        zero1_q[k] <= len_i[k] == '0;
      end
      sb1_q <= sb_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rfrac    = (r == 0) ? cfg_i.min_aspect : cfg_i.min_side_ratio;
      rfail[r] = (RCW'(lo1_q[r]) << RATIO_SH) < (RCW'(rfrac) * RCW'(hi1_q[r]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      edge2_q   <= (ECW'(emin1_q) << ESH) < ECW'(em1_q);
      aspect2_q <= rfail[0];
      ratio2_q  <= rfail[1] || rfail[2];
      for (int j = 0; j < 2; j++) begin
        pph2_q[j]  <= PPW'(cfg_i.min_parallel_cos) * PPW'(pe1_q[j][RPW-1:EW]);
        ppl2_q[j]  <= PPW'(cfg_i.min_parallel_cos) * PPW'(pe1_q[j][EW-1:0]);
        zero2_q[j] <= zero1_q[j] || zero1_q[j+2];
      end
      for (int k = 0; k < 4; k++) begin
        pph2_q[k+2]  <= PPW'(cfg_i.max_corner_cos) * PPW'(pe1_q[k+2][RPW-1:EW]);
        ppl2_q[k+2]  <= PPW'(cfg_i.max_corner_cos) * PPW'(pe1_q[k+2][EW-1:0]);
        zero2_q[k+2] <= zero1_q[(k+3)&3] || zero1_q[k];
      end
      for (int j = 0; j < 6; j++) dot2_q[j] <= sb1_q.dot[j];
      small2_q  <= sb1_q.area_low;
      large2_q  <= sb1_q.area_high;
      border2_q <= sb1_q.border;
    end
  end

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      prod = (CMPW'(pph2_q[j]) << EW) + CMPW'(ppl2_q[j]);
      lhs  = CMPW'(dot2_q[j]) << COS_SH;
      if (j < 2) begin
        par_fail[j[0]] = zero2_q[j] ? (cfg_i.min_parallel_cos != '0) : (lhs < prod);
      end else begin
        cor_fail[2'(j-2)] = zero2_q[j] ? (cfg_i.max_corner_cos < COS_ONE) : (lhs > prod);
      end
    end
    if (small2_q)           code_d = REJ_SMALL;
    else if (large2_q)      code_d = REJ_LARGE;
    else if (edge2_q)       code_d = REJ_EDGE;
    else if (aspect2_q)     code_d = REJ_ASPECT;
    else if (ratio2_q)      code_d = REJ_RATIO;
    else if (|par_fail)     code_d = REJ_PARALLEL;
    else if (|cor_fail)     code_d = REJ_CORNER;
    else if (border2_q)     code_d = REJ_BORDER;
    else                    code_d = REJ_NONE;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      code3_q <= code_d;
    end
  end

  assign valid_o = v3_q;
  assign code_o  = code3_q;

endmodule

// File: design/qpf_outbuf.sv
// Output register with a skid word, so one more result is taken while the output word waits.
// Depends on qpf_pkg.
module qpf_outbuf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [qpf_pkg::CODE_W-1:0] code_i,
  output logic                       ready_o,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [qpf_pkg::OUT_W-1:0]  m_tdata_o
);
  import qpf_pkg::*;

  logic             ov_q, sk_v_q;
  logic [OUT_W-1:0] od_q, sk_q, res;
  logic             take;

  assign res     = OUT_W'({code_i, code_i == REJ_NONE});
  assign take    = !ov_q || m_tready_i;
  assign ready_o = !sk_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      sk_v_q <= 1'b0;
    end else if (take) begin
      ov_q   <= sk_v_q || valid_i;
      sk_v_q <= 1'b0;
    end else if (valid_i && !sk_v_q) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      od_q <= sk_v_q ? sk_q : res;
    end else if (valid_i && !sk_v_q) begin
      sk_q <= res;
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = od_q;

endmodule

// File: design/qpf_checker.sv
// Port-level checks for the quad plausibility filter, bound to the top level.
// Depends on qpf_pkg and quad_plausibility_filter_core.
module qpf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_tready_i,
  input logic                      m_tvalid_i,
  input logic                      m_tready_i,
  input logic [qpf_pkg::OUT_W-1:0] m_tdata_i
);
  import qpf_pkg::*;

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_tvalid_i)
    else $error("result word valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("stalled result word changed");

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[0] == (m_tdata_i[4:1] == REJ_NONE))
    else $error("pass flag disagrees with reject code");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[4:1] <= REJ_BORDER && m_tdata_i[7:5] == 3'b000)
    else $error("reject code out of range");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_i |-> s_tready_i)
    else $error("input stalled with empty output");

endmodule

bind quad_plausibility_filter_core qpf_checker u_qpf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_tready_o),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o)
);

// File: test/tb_top.sv
// Self-checking bench for quad_plausibility_filter_core: directed and random quads under
// several register settings, each result word checked against an internal predictor.
// Depends on qpf_pkg and the design sources.
`timescale 1ns / 100ps

module tb_top;
  import qpf_pkg::*;

  localparam int ITEMS_PER_PHASE = 250;
  localparam int N_PHASES        = 7;
  localparam int DRAIN_CYCLES    = 48;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic            plausible;
    logic [CODE_W-1:0] code;
  } verdict_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  cfg_t            regs = CFG_RESET;
  logic [IN_W-1:0] pending_quads[$];
  verdict_t        expected_verdicts[$];
  int              errors = 0;
  int              quads_sent = 0;
  int              verdicts_seen = 0;
  int              code_hits[9];
  int              cycles = 0;
  int              burst_left = 0;
  int              gap_left = 0;
  int              stall_mode = 0;

  quad_plausibility_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned edge_root(longint unsigned v);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [127:0] wide_mul(longint unsigned a, longint unsigned b);
    return {64'd0, a} * {64'd0, b};
  endfunction

  function automatic bit ratio_below(longint unsigned a, longint unsigned b,
                                     longint unsigned frac);
    longint unsigned lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return wide_mul(lo, 65536) < wide_mul(frac, hi);
  endfunction

  function automatic logic [CODE_W-1:0] judge_quad(logic [IN_W-1:0] d, cfg_t c);
    longint x[4], y[4], ex[4], ey[4];
    longint a2s, w, h, mm, t, xr, yr;
    longint unsigned l2[4], e[4], a2, wh, emin, dd;
    int n, ia, ib;
    for (int i = 0; i < 4; i++) begin
      x[i] = longint'($signed(d[32*i +: 16]));
      y[i] = longint'($signed(d[32*i+16 +: 16]));
    end
    w = longint'(d[128 +: 11]);
    h = longint'(d[139 +: 11]);
    mm = (w < h) ? w : h;
    wh = w * h;
    a2s = (x[0] - x[2]) * (y[1] - y[3]) - (x[1] - x[3]) * (y[0] - y[2]);
    a2 = (a2s < 0) ? -a2s : a2s;
    if (wide_mul(a2, 32768) < wide_mul(256 * c.min_area_frac, wh)) return REJ_SMALL;
    if (wide_mul(a2, 32768) > wide_mul(256 * c.max_area_frac, wh)) return REJ_LARGE;
    ex[0] = x[1] - x[0]; ey[0] = y[1] - y[0];
    ex[1] = x[2] - x[1]; ey[1] = y[2] - y[1];
    ex[2] = x[2] - x[3]; ey[2] = y[2] - y[3];
    ex[3] = x[3] - x[0]; ey[3] = y[3] - y[0];
    for (int i = 0; i < 4; i++) begin
      l2[i] = ex[i] * ex[i] + ey[i] * ey[i];
      e[i] = edge_root(l2[i] << 14);
    end
    emin = e[0];
    for (int i = 1; i < 4; i++) if (e[i] < emin) emin = e[i];
    if (wide_mul(emin, 65536) < wide_mul(c.min_edge_frac * mm, 16 * 128)) return REJ_EDGE;
    if (ratio_below(e[0] + e[2], e[1] + e[3], c.min_aspect)) return REJ_ASPECT;
    if (ratio_below(e[0], e[2], c.min_side_ratio) || ratio_below(e[1], e[3], c.min_side_ratio))
      return REJ_RATIO;
    for (int i = 0; i < 2; i++) begin
      if (l2[i] == 0 || l2[i+2] == 0) begin
        if (c.min_parallel_cos > 0) return REJ_PARALLEL;
      end else begin
        a2s = ex[i] * ex[i+2] + ey[i] * ey[i+2];
        dd = (a2s < 0) ? -a2s : a2s;
        if (wide_mul(dd, 64'd1 << 30) < wide_mul(c.min_parallel_cos, e[i] * e[i+2]))
          return REJ_PARALLEL;
      end
    end
    for (int i = 0; i < 4; i++) begin
      ia = (i + 3) % 4;
      ib = i;
      if (l2[ia] == 0 || l2[ib] == 0) begin
        if (c.max_corner_cos < 65536) return REJ_CORNER;
      end else begin
        a2s = ex[ia] * ex[ib] + ey[ia] * ey[ib];
        dd = (a2s < 0) ? -a2s : a2s;
        if (wide_mul(dd, 64'd1 << 30) > wide_mul(c.max_corner_cos, e[ia] * e[ib]))
          return REJ_CORNER;
      end
    end
    t = ((mm > 400) ? mm : 400) * 16;
    xr = 100 * (w - 1) * 16 - t;
    yr = 100 * (h - 1) * 16 - t;
    n = 0;
    for (int i = 0; i < 4; i++)
      if (100 * x[i] <= t || 100 * y[i] <= t || 100 * x[i] >= xr || 100 * y[i] >= yr) n++;
    if (n > c.max_border_corners) return REJ_BORDER;
    return REJ_NONE;
  endfunction

  function automatic logic [IN_W-1:0] pack_quad(int x[4], int y[4], int w, int h);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 4; i++) begin
      d[32*i +: 16]    = x[i][15:0];
      d[32*i+16 +: 16] = y[i][15:0];
    end
    d[128 +: 11] = w[10:0];
    d[139 +: 11] = h[10:0];
    return d;
  endfunction

  function automatic logic [IN_W-1:0] random_quad();
    int x[4], y[4], w, h, cx, cy, hw, hh, j, kind;
    logic [IN_W-1:0] d;
    kind = $urandom_range(0, 99);
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(32, 2047);
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(32, 2047);
    if (kind < 15) begin
      d = '0;
      for (int i = 0; i < 5; i++) d[32*i +: 32] = $urandom();
      d[IN_W-1:150] = '0;
      return d;
    end
    cx = $urandom_range(0, w * 16);
    cy = $urandom_range(0, h * 16);
    hw = $urandom_range(8, w * 8 + 8);
    hh = $urandom_range(8, h * 8 + 8);
    j = (kind < 70) ? (hw + hh) / 12 + 1 : (hw + hh) / 2 + 1;
    x[0] = cx - hw; y[0] = cy - hh;
    x[1] = cx + hw; y[1] = cy - hh;
    x[2] = cx + hw; y[2] = cy + hh;
    x[3] = cx - hw; y[3] = cy + hh;
    for (int i = 0; i < 4; i++) begin
      x[i] += $urandom_range(0, 2 * j) - j;
      y[i] += $urandom_range(0, 2 * j) - j;
      if (x[i] > 32767) x[i] = 32767;
      if (y[i] > 32767) y[i] = 32767;
    end
    if (kind >= 88) begin
      j = $urandom_range(0, 3);
      x[(j + 1) % 4] = x[j];
      y[(j + 1) % 4] = y[j];
    end
    return pack_quad(x, y, w, h);
  endfunction

  function automatic cfg_t random_regs();
    cfg_t c;
    c.min_area_frac      = FRW'($urandom_range(0, 8000));
    c.max_area_frac      = FRW'($urandom_range(30000, 65535));
    c.min_edge_frac      = FRW'($urandom_range(0, 6000));
    c.min_aspect         = FRW'($urandom_range(0, 40000));
    c.min_side_ratio     = FRW'($urandom_range(0, 40000));
    c.min_parallel_cos   = FRW'($urandom_range(0, 65535));
    c.max_corner_cos     = ($urandom_range(0, 3) == 0) ? CCW'($urandom()) :
                                                          CCW'($urandom_range(20000, 65536));
    c.max_border_corners = MBW'($urandom());
    return c;
  endfunction

  task automatic enqueue_quad(logic [IN_W-1:0] d);
    pending_quads = {pending_quads, d};
  endtask

  task automatic load_regs(cfg_t c);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      case (i)
        0: begin cfg_index <= CFG_MIN_AREA_FRAC;      cfg_data <= CFG_DW'(c.min_area_frac); end
        1: begin cfg_index <= CFG_MAX_AREA_FRAC;      cfg_data <= CFG_DW'(c.max_area_frac); end
        2: begin cfg_index <= CFG_MIN_EDGE_FRAC;      cfg_data <= CFG_DW'(c.min_edge_frac); end
        3: begin cfg_index <= CFG_MIN_ASPECT;         cfg_data <= CFG_DW'(c.min_aspect); end
        4: begin cfg_index <= CFG_MIN_SIDE_RATIO;     cfg_data <= CFG_DW'(c.min_side_ratio); end
        5: begin cfg_index <= CFG_MIN_PARALLEL_COS;   cfg_data <= CFG_DW'(c.min_parallel_cos); end
        6: begin cfg_index <= CFG_MAX_CORNER_COS;     cfg_data <= CFG_DW'(c.max_corner_cos); end
        default: begin
          cfg_index <= CFG_MAX_BORDER_CORNERS;
          cfg_data  <= CFG_DW'(c.max_border_corners);
        end
      endcase
      do @(posedge clk_i); while (!cfg_ready);
    end
    regs = c;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_quads.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    logic            nv;
    logic [IN_W-1:0] nd;
    verdict_t        v;
    nv = s_tvalid;
    nd = s_tdata;
    if (s_tvalid && s_tready) begin
      v.code      = judge_quad(s_tdata, regs);
      v.plausible = (v.code == REJ_NONE);
      expected_verdicts = {expected_verdicts, v};
      quads_sent++;
    end
    if (!s_tvalid || s_tready) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_quads.size() > 0) begin
        nd = pending_quads.pop_front();
        nv = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      s_tvalid <= nv;
      s_tdata  <= nd;
    end
  end

  // receiver: stall pattern redrawn at random from four modes
  always @(posedge clk_i) begin
    verdict_t got, want;
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 9) >= 3);
      2: m_tready <= (cycles % 8 != 0);
      default: m_tready <= ((cycles / 16) % 2 == 0);
    endcase
    if (m_tvalid && m_tready) begin
      got.plausible = m_tdata[0];
      got.code      = m_tdata[4:1];
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, actual plausible=%0d code=%0d",
                 $time, got.plausible, got.code);
      end else begin
        want = expected_verdicts.pop_front();
        if (got.code <= REJ_BORDER) code_hits[got.code]++;
        if (got.plausible !== want.plausible) begin
          errors++;
          $display("%0t: plausible expected %0d actual %0d", $time, want.plausible,
                   got.plausible);
        end
        if (got.code !== want.code) begin
          errors++;
          $display("%0t: reject_code expected %0d actual %0d", $time, want.code, got.code);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, expected_verdicts.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int x[4], y[4];
    cfg_t c;
    foreach (code_hits[i]) code_hits[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    x = '{-32768, -32768, -32768, -32768}; y = x;
    enqueue_quad(pack_quad(x, y, 2047, 2047));
    x = '{32767, 32767, 32767, 32767}; y = x;
    enqueue_quad(pack_quad(x, y, 0, 0));
    x = '{-32768, 32767, 32767, -32768}; y = '{-32768, -32768, 32767, 32767};
    enqueue_quad(pack_quad(x, y, 2047, 2047));
    enqueue_quad(pack_quad(x, y, 1, 1));
    enqueue_quad(pack_quad(x, y, 0, 2047));
    x = '{1600, 14400, 14400, 1600}; y = '{1600, 1600, 11200, 11200};
    enqueue_quad(pack_quad(x, y, 1000, 800));
    enqueue_quad(pack_quad(x, y, 2047, 2047));
    enqueue_quad(pack_quad(x, y, 900, 710));
    x = '{1600, 14400, 14400, 1600}; y = '{1600, 1600, 1700, 1700};
    enqueue_quad(pack_quad(x, y, 1000, 800));
    x = '{1600, 14400, 8000, 7800}; y = '{1600, 1600, 11200, 11200};
    enqueue_quad(pack_quad(x, y, 1000, 800));
    x = '{1600, 14400, 14400, 1600}; y = '{1600, 3000, 11200, 6000};
    enqueue_quad(pack_quad(x, y, 1000, 800));
    x = '{1600, 14400, 1600, 1600}; y = '{1600, 1600, 11200, 11200};
    enqueue_quad(pack_quad(x, y, 1000, 800));
    x = '{1600, 1600, 14400, 1600}; y = '{1600, 1600, 11200, 11200};
    enqueue_quad(pack_quad(x, y, 1000, 800));
    x = '{16, 15984, 15984, 16}; y = '{16, 16, 12784, 12784};
    enqueue_quad(pack_quad(x, y, 1000, 800));
    x = '{1600, 14400, 14400, 1600}; y = '{1600, 1600, 11200, 11200};
    enqueue_quad(pack_quad(x, y, 1000, 1));
    for (int i = 0; i < ITEMS_PER_PHASE; i++) enqueue_quad(random_quad());
    drain();

    for (int p = 0; p < N_PHASES - 1; p++) begin
      case (p)
        0: c = '{0, 65535, 0, 0, 0, 0, 17'd65536, 3'd4};
        1: c = '{16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'd0, 3'd0};
        2: c = '{0, 65535, 0, 0, 0, 0, 17'h1FFFF, 3'd7};
        3: c = CFG_RESET;
        default: c = random_regs();
      endcase
      load_regs(c);
      if (p == 2) begin
        x = '{1600, 1600, 14400, 1600}; y = '{1600, 1600, 11200, 11200};
        enqueue_quad(pack_quad(x, y, 1000, 800));
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) enqueue_quad(random_quad());
      drain();
    end

    $display("%0d quads sent, %0d verdicts checked over %0d register settings", quads_sent,
             verdicts_seen, N_PHASES);
    $display("verdicts by code 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d", code_hits[0],
             code_hits[1], code_hits[2], code_hits[3], code_hits[4], code_hits[5],
             code_hits[6], code_hits[7], code_hits[8]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
